@@ src/bie_pkg.sv @@
// ----------------------------------------------------------------------------
// bie_pkg
// Shared types and constants of the bitmap index engine.
// ----------------------------------------------------------------------------
package bie_pkg;

  localparam int unsigned MAX_ROWS_DEF = 4096;
  localparam int unsigned MAX_CARD_DEF = 32;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_UPDATE = 3'd1,
    OP_REMOVE = 3'd2,
    OP_COUNT  = 3'd3,
    OP_LOOKUP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BOP_SET = 2'd0,
    BOP_CLR = 2'd1,
    BOP_TOG = 2'd2
  } bop_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] row_id;
    logic [4:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  found_value;
    logic [12:0] bit_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic rd;
    logic wr;
    logic zero;
    bop_e bop;
    logic acc_clr;
    logic acc_en;
    logic rc_inc;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_bit;
    logic rc_full;
  } dp_stat_t;

endpackage

@@ src/bie_datapath.sv @@
// ----------------------------------------------------------------------------
// bie_datapath
// Bitmap word memory, read-modify-write logic, popcount accumulator, row count.
// ----------------------------------------------------------------------------
module bie_datapath #(
  parameter  int unsigned MAX_ROWS        = bie_pkg::MAX_ROWS_DEF,
  parameter  int unsigned MAX_CARDINALITY = bie_pkg::MAX_CARD_DEF,
  localparam int unsigned WORDS           = (MAX_ROWS + 63) / 64,
  localparam int unsigned WORD_W          = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int unsigned MAP_W           = $clog2(MAX_CARDINALITY),
  localparam int unsigned ADDR_W          = MAP_W + WORD_W,
  localparam int unsigned RC_W            = $clog2(MAX_ROWS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bie_pkg::dp_cmd_t    cmd_i,
  input  logic [ADDR_W-1:0]   addr_i,
  input  logic [5:0]          bitpos_i,
  output bie_pkg::dp_stat_t   stat_o,
  output logic [RC_W-1:0]     row_count_o,
  output logic [RC_W-1:0]     acc_o
);

  localparam int unsigned DEPTH  = 1 << ADDR_W;

  logic [63:0]     mem_q [DEPTH];
  logic [63:0]     rdata_q;
  logic [63:0]     mask;
  logic [63:0]     wdata;
  logic [RC_W-1:0] row_count_q;
  logic [RC_W-1:0] acc_q;

  function automatic logic [6:0] popcount64(input logic [63:0] w);
    logic [6:0] s;
    s = '0;
    for (int i = 0; i < 64; i++) begin
      s = s + 7'(w[i]);
    end
    return s;
  endfunction

  assign mask = 64'(1) << bitpos_i;

  always_comb begin
    unique case (cmd_i.bop)
      bie_pkg::BOP_SET: wdata = rdata_q | mask;
      bie_pkg::BOP_CLR: wdata = rdata_q & ~mask;
      bie_pkg::BOP_TOG: wdata = rdata_q ^ mask;
      default:          wdata = rdata_q;
    endcase
    if (cmd_i.zero) begin
      wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      acc_q       <= '0;
    end else begin
      if (cmd_i.rc_inc) begin
        row_count_q <= row_count_q + RC_W'(1);
      end
      if (cmd_i.acc_clr) begin
        acc_q <= '0;
      end else if (cmd_i.acc_en) begin
        acc_q <= acc_q + RC_W'(popcount64(rdata_q));
      end
    end
  end

  assign stat_o.cur_bit = rdata_q[bitpos_i];
  assign stat_o.rc_full = (row_count_q >= RC_W'(MAX_ROWS));
  assign row_count_o    = row_count_q;
  assign acc_o          = acc_q;

endmodule

@@ src/bie_ctrl.sv @@
// ----------------------------------------------------------------------------
// bie_ctrl
// Sequencer: clearing pass, operation decode, bitmap scan, RMW loop, count.
// ----------------------------------------------------------------------------
module bie_ctrl #(
  parameter  int unsigned MAX_ROWS        = bie_pkg::MAX_ROWS_DEF,
  parameter  int unsigned MAX_CARDINALITY = bie_pkg::MAX_CARD_DEF,
  localparam int unsigned WORDS           = (MAX_ROWS + 63) / 64,
  localparam int unsigned WORD_W          = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int unsigned MAP_W           = $clog2(MAX_CARDINALITY),
  localparam int unsigned ADDR_W          = MAP_W + WORD_W,
  localparam int unsigned RC_W            = $clog2(MAX_ROWS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bie_pkg::in_item_t   in_item_i,
  input  logic                mode_i,
  input  logic [5:0]          card_i,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output bie_pkg::out_item_t  res_o,
  output bie_pkg::dp_cmd_t    cmd_o,
  output logic [ADDR_W-1:0]   addr_o,
  output logic [5:0]          bitpos_o,
  input  bie_pkg::dp_stat_t   stat_i,
  input  logic [RC_W-1:0]     row_count_i,
  input  logic [RC_W-1:0]     acc_i
);

  localparam int unsigned WCNT_W = $clog2(WORDS + 1);
  localparam int unsigned CNT_W  = MAP_W + 1;
  localparam int unsigned CC_W   = (CNT_W > 6) ? CNT_W : 6;
  localparam int unsigned VC_W   = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned RCMP_W = (RC_W > 12) ? RC_W : 12;
  localparam int unsigned ROWI_W = $clog2(MAX_ROWS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_RD, S_WR, S_CNT, S_DONE
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   clr_q;
  logic [2:0]          op_q;
  logic [CNT_W-1:0]    val_q;
  logic [ROWI_W-1:0]   trow_q;
  logic [CNT_W-1:0]    m_q;
  logic [CNT_W-1:0]    hi_q;
  bie_pkg::bop_e       bop_q;
  logic                pend_q;
  logic [WCNT_W-1:0]   w_q;
  logic                cvld_q;
  bie_pkg::status_e    res_status_q;
  logic [4:0]          res_found_q;
  logic                res_cnt_q;

  logic [CC_W-1:0]     card_ext;
  logic [CNT_W-1:0]    card_eff;
  logic [CNT_W-1:0]    n_maps;
  logic [CNT_W-1:0]    val_c;
  logic                val_inv;
  logic                cnt_inv;
  logic                absent;
  logic                accept;
  logic [WORD_W-1:0]   row_word;

  // clamp the cardinality register into 2..MAX_CARDINALITY
  assign card_ext = CC_W'(card_i);
  always_comb begin
    if (card_ext < CC_W'(2)) begin
      card_eff = CNT_W'(2);
    end else if (card_ext > CC_W'(MAX_CARDINALITY)) begin
      card_eff = CNT_W'(MAX_CARDINALITY);
    end else begin
      card_eff = CNT_W'(card_ext);
    end
  end

  assign n_maps   = mode_i ? (card_eff - CNT_W'(1)) : card_eff;
  assign val_c    = CNT_W'(in_item_i.value);
  assign val_inv  = VC_W'(in_item_i.value) >= VC_W'(card_eff);
  assign cnt_inv  = VC_W'(in_item_i.value) >= VC_W'(n_maps);
  assign absent   = RCMP_W'(in_item_i.row_id) >= RCMP_W'(row_count_i);
  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign row_word = WORD_W'(trow_q >> 6);
  assign bitpos_o = trow_q[5:0];

  // datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.bop     = bop_q;
    addr_o        = {m_q[MAP_W-1:0], row_word};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr   = 1'b1;
        cmd_o.zero = 1'b1;
        addr_o     = clr_q;
      end
      S_IDLE: begin
        cmd_o.acc_clr = accept;
        cmd_o.rc_inc  = accept && (in_item_i.opcode == bie_pkg::OP_APPEND) &&
                        !val_inv && !stat_i.rc_full;
      end
      S_SCAN_RD: cmd_o.rd = (m_q != n_maps);
      S_RD:      cmd_o.rd = (m_q != hi_q);
      S_WR:      cmd_o.wr = 1'b1;
      S_CNT: begin
        cmd_o.rd     = (w_q != WCNT_W'(WORDS));
        cmd_o.acc_en = cvld_q;
        addr_o       = {val_q[MAP_W-1:0], WORD_W'(w_q)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      op_q         <= '0;
      val_q        <= '0;
      trow_q       <= '0;
      m_q          <= '0;
      hi_q         <= '0;
      bop_q        <= bie_pkg::BOP_SET;
      pend_q       <= 1'b0;
      w_q          <= '0;
      cvld_q       <= 1'b0;
      res_status_q <= bie_pkg::ST_OK;
      res_found_q  <= '0;
      res_cnt_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q         <= in_item_i.opcode;
            val_q        <= val_c;
            trow_q       <= ROWI_W'(in_item_i.row_id);
            res_status_q <= bie_pkg::ST_OK;
            res_found_q  <= '0;
            res_cnt_q    <= 1'b0;
            pend_q       <= 1'b0;
            m_q          <= '0;
            unique case (in_item_i.opcode)
              bie_pkg::OP_APPEND: begin
                if (val_inv) begin
                  res_status_q <= bie_pkg::ST_INVALID;
                  state_q      <= S_DONE;
                end else if (stat_i.rc_full) begin
                  res_status_q <= bie_pkg::ST_FULL;
                  state_q      <= S_DONE;
                end else begin
                  trow_q  <= ROWI_W'(row_count_i);
                  m_q     <= val_c;
                  hi_q    <= mode_i ? n_maps : (val_c + CNT_W'(1));
                  bop_q   <= bie_pkg::BOP_SET;
                  state_q <= S_RD;
                end
              end
              bie_pkg::OP_UPDATE: begin
                if (val_inv) begin
                  res_status_q <= bie_pkg::ST_INVALID;
                  state_q      <= S_DONE;
                end else if (absent) begin
                  res_status_q <= bie_pkg::ST_NOT_FOUND;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_SCAN_RD;
                end
              end
              bie_pkg::OP_REMOVE, bie_pkg::OP_LOOKUP: begin
                if (absent) begin
                  res_status_q <= bie_pkg::ST_NOT_FOUND;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_SCAN_RD;
                end
              end
              bie_pkg::OP_COUNT: begin
                if (cnt_inv) begin
                  res_status_q <= bie_pkg::ST_INVALID;
                  state_q      <= S_DONE;
                end else begin
                  w_q       <= '0;
                  cvld_q    <= 1'b0;
                  res_cnt_q <= 1'b1;
                  state_q   <= S_CNT;
                end
              end
              default: begin
                res_status_q <= bie_pkg::ST_INVALID;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          if (m_q == n_maps) begin
            res_status_q <= bie_pkg::ST_NOT_FOUND;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (stat_i.cur_bit) begin
            unique case (op_q)
              bie_pkg::OP_LOOKUP: begin
                res_found_q <= 5'(m_q);
                state_q     <= S_DONE;
              end
              bie_pkg::OP_REMOVE: begin
                hi_q    <= mode_i ? n_maps : (m_q + CNT_W'(1));
                bop_q   <= bie_pkg::BOP_CLR;
                state_q <= S_RD;
              end
              bie_pkg::OP_UPDATE: begin
                if (m_q == val_q) begin
                  res_status_q <= bie_pkg::ST_NOT_FOUND;
                  state_q      <= S_DONE;
                end else if (!mode_i) begin
                  // clear the old bitmap, then set the new one
                  hi_q    <= m_q + CNT_W'(1);
                  bop_q   <= bie_pkg::BOP_CLR;
                  pend_q  <= 1'b1;
                  state_q <= S_RD;
                end else begin
                  // flip the bitmaps between old and new value
                  if (m_q < val_q) begin
                    hi_q <= val_q;
                  end else begin
                    m_q  <= val_q;
                    hi_q <= m_q;
                  end
                  bop_q   <= bie_pkg::BOP_TOG;
                  state_q <= S_RD;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end else begin
            m_q     <= m_q + CNT_W'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_RD: begin
          if (m_q == hi_q) begin
            if (pend_q) begin
              pend_q <= 1'b0;
              m_q    <= val_q;
              hi_q   <= val_q + CNT_W'(1);
              bop_q  <= bie_pkg::BOP_SET;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            state_q <= S_WR;
          end
        end
        S_WR: begin
          m_q     <= m_q + CNT_W'(1);
          state_q <= S_RD;
        end
        S_CNT: begin
          cvld_q <= (w_q != WCNT_W'(WORDS));
          if (w_q != WCNT_W'(WORDS)) begin
            w_q <= w_q + WCNT_W'(1);
          end else if (!cvld_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = res_status_q;
  assign res_o.found_value = res_found_q;
  assign res_o.bit_count   = res_cnt_q ? 13'(acc_i) : 13'd0;

endmodule

@@ src/bitmap_index_engine.sv @@
// ----------------------------------------------------------------------------
// bitmap_index_engine
// Uncompressed bitmap index, equality or range encoded, one bitmap per value (one fewer in range mode).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one operation
//   per transfer: append, update, remove, count bitmap, lookup row.
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly
//   one result per operation, in order.
//   One operation at a time, on the single-port word memory (one access
//   per cycle). After reset the memory is zeroed one word per cycle, with
//   in_stall_o high meanwhile; APB writes work throughout.
//   A finished result sits in the output register; while the receiver
//   stalls the engine may accept one more item and hold its result
//   internally until the output register frees up.
//   Registers (APB): 0x0 encoding_mode, 0x4 cardinality; write only when idle.
// ----------------------------------------------------------------------------
module bitmap_index_engine #(
  parameter int unsigned MAX_ROWS        = bie_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_CARDINALITY = bie_pkg::MAX_CARD_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bie_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bie_pkg::out_item_t  out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned WORDS  = (MAX_ROWS + 63) / 64;
  localparam int unsigned WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned MAP_W  = $clog2(MAX_CARDINALITY);
  localparam int unsigned ADDR_W = MAP_W + WORD_W;
  localparam int unsigned RC_W   = $clog2(MAX_ROWS + 1);

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_CARD = 1'b1;

  logic                mode_q;
  logic [5:0]          card_q;
  logic                out_vld_q;
  bie_pkg::out_item_t  out_q;
  logic                out_free;
  logic                res_valid;
  bie_pkg::out_item_t  res;
  bie_pkg::dp_cmd_t    cmd;
  bie_pkg::dp_stat_t   stat;
  logic [ADDR_W-1:0]   addr;
  logic [5:0]          bitpos;
  logic [RC_W-1:0]     row_count;
  logic [RC_W-1:0]     acc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      card_q <= 6'd32;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_MODE: mode_q <= pwdata[0];
        REG_CARD: card_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CARD) ? {26'd0, card_q} : {31'd0, mode_q};

  bie_ctrl #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_CARDINALITY (MAX_CARDINALITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .mode_i      (mode_q),
    .card_i      (card_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cmd_o       (cmd),
    .addr_o      (addr),
    .bitpos_o    (bitpos),
    .stat_i      (stat),
    .row_count_i (row_count),
    .acc_i       (acc)
  );

  bie_datapath #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_CARDINALITY (MAX_CARDINALITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .bitpos_i    (bitpos),
    .stat_o      (stat),
    .row_count_o (row_count),
    .acc_o       (acc)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && out_free) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // one item in flight: an accepted transfer closes the input next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an operation is in flight");

  // a finished result waits when the output register is busy
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !out_free) |=> (res_valid && $stable(res)))
    else $error("pending result lost");

  // non-ok results carry zero payload
  a_clean_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != bie_pkg::ST_OK)) |->
      ((out_item_o.found_value == 5'd0) && (out_item_o.bit_count == 13'd0)))
    else $error("payload set on a failed operation");

  a_row_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_count <= RC_W'(MAX_ROWS))
    else $error("row count past limit");

endmodule

@@ verif/tb_bitmap_index_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_index_engine
// Self-checking bench for the bitmap index engine: directed tables of
// operations followed by random traffic under three idle/stall settings,
// every result compared in order against a typed-in or modeled result.
// ----------------------------------------------------------------------------
module tb_bitmap_index_engine;

  localparam int unsigned ROWS    = 4096;
  localparam int unsigned NMAPS   = 32;
  localparam int unsigned NRANDOM = 1250;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 200;

  // register byte addresses
  localparam logic [2:0] REG_MODE = 3'h0;
  localparam logic [2:0] REG_CARD = 3'h4;

  // operation codes outside op_e
  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  bie_pkg::in_item_t  in_item_i;
  bie_pkg::out_item_t out_item_o;
  logic psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  bitmap_index_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // --------------------------------------------------------------------------
  // Index model: bitmaps, appended row count, and the two registers.
  // --------------------------------------------------------------------------
  logic [ROWS-1:0] idx_maps [NMAPS];
  int unsigned     idx_rows;
  logic            idx_mode;
  logic [5:0]      idx_card;

  bie_pkg::out_item_t result_q[$];
  int  fails = 0;
  longint unsigned cycles = 0;

  // idle/stall rates in percent
  int unsigned send_idle_pct, recv_stall_pct;

  function automatic int unsigned card_eff();
    if (idx_card < 2) return 2;
    if (idx_card > NMAPS) return NMAPS;
    return idx_card;
  endfunction

  function automatic int unsigned maps_used();
    return idx_mode ? card_eff() - 1 : card_eff();
  endfunction

  // lowest set bitmap in use for a row, -1 when the row holds no value
  function automatic int row_val(int unsigned row);
    if (row >= idx_rows) return -1;
    for (int v = 0; v < maps_used(); v++)
      if (idx_maps[v][row]) return v;
    return -1;
  endfunction

  function automatic bie_pkg::out_item_t index_apply(bie_pkg::in_item_t it);
    bie_pkg::out_item_t r;
    int cur;
    int unsigned val, n, lo, hi, cnt;
    r = '0;
    r.status = bie_pkg::ST_OK;
    val = it.value;
    n = maps_used();
    case (it.opcode)
      bie_pkg::OP_APPEND: begin
        if (val >= card_eff()) r.status = bie_pkg::ST_INVALID;
        else if (idx_rows >= ROWS) r.status = bie_pkg::ST_FULL;
        else begin
          if (!idx_mode) idx_maps[val][idx_rows] = 1'b1;
          else for (int i = val; i < n; i++) idx_maps[i][idx_rows] = 1'b1;
          idx_rows++;
        end
      end
      bie_pkg::OP_UPDATE: begin
        if (val >= card_eff()) r.status = bie_pkg::ST_INVALID;
        else begin
          cur = row_val(it.row_id);
          if (cur < 0 || cur == val) r.status = bie_pkg::ST_NOT_FOUND;
          else if (!idx_mode) begin
            idx_maps[cur][it.row_id] = 1'b0;
            idx_maps[val][it.row_id] = 1'b1;
          end else begin
            lo = (cur < val) ? cur : val;
            hi = (cur < val) ? val : cur;
            for (int i = lo; i < hi; i++) idx_maps[i][it.row_id] ^= 1'b1;
          end
        end
      end
      bie_pkg::OP_REMOVE: begin
        cur = row_val(it.row_id);
        if (cur < 0) r.status = bie_pkg::ST_NOT_FOUND;
        else if (!idx_mode) idx_maps[cur][it.row_id] = 1'b0;
        else for (int i = cur; i < n; i++) idx_maps[i][it.row_id] = 1'b0;
      end
      bie_pkg::OP_COUNT: begin
        if (val >= n) r.status = bie_pkg::ST_INVALID;
        else begin
          cnt = $countones(idx_maps[val]);
          r.bit_count = cnt[12:0];
        end
      end
      bie_pkg::OP_LOOKUP: begin
        cur = row_val(it.row_id);
        if (cur < 0) r.status = bie_pkg::ST_NOT_FOUND;
        else r.found_value = cur[4:0];
      end
      default: r.status = bie_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving helpers
  // --------------------------------------------------------------------------
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_MODE) idx_mode = data[0];
    else idx_card = data[5:0];
    @(posedge clk_i);
  endtask

  // wait out all pending results, then let the engine settle
  task automatic drain();
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic mode, logic [5:0] card);
    drain();
    reg_write(REG_MODE, {31'd0, mode});
    reg_write(REG_CARD, {26'd0, card});
  endtask

  // one transfer; expected result is predicted, or given and cross-checked
  task automatic send_op(bie_pkg::in_item_t it, bit has_fixed = 0,
                         bie_pkg::out_item_t fixed = '0);
    bie_pkg::out_item_t pred;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = index_apply(it);
    if (has_fixed && pred != fixed)
      $display("%0t table entry disagrees with model: expected %h model %h",
               $time, fixed, pred);
    result_q.push_back(has_fixed ? fixed : pred);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_item_o);
        fails++;
      end else begin
        bie_pkg::out_item_t exp_r;
        exp_r = result_q.pop_front();
        if (exp_r.status !== out_item_o.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp_r.status,
                   out_item_o.status);
          fails++;
        end
        if (exp_r.found_value !== out_item_o.found_value) begin
          $display("%0t found_value: expected %0d actual %0d", $time,
                   exp_r.found_value, out_item_o.found_value);
          fails++;
        end
        if (exp_r.bit_count !== out_item_o.bit_count) begin
          $display("%0t bit_count: expected %0d actual %0d", $time,
                   exp_r.bit_count, out_item_o.bit_count);
          fails++;
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bitmap_index_engine: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table: op, row, value, and an optional typed-in result.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [2:0]  op;
    logic [11:0] row;
    logic [4:0]  val;
    bit          fixed;
    logic [1:0]  st;
    logic [4:0]  fv;
    logic [12:0] cnt;
  } vec_t;

  vec_t dir_tbl[] = '{
    // empty store right after reset
    '{bie_pkg::OP_LOOKUP, 12'd0,   5'd0,  1, bie_pkg::ST_NOT_FOUND, 5'd0, 13'd0},
    '{bie_pkg::OP_REMOVE, 12'hFFF, 5'd0,  1, bie_pkg::ST_NOT_FOUND, 5'd0, 13'd0},
    '{bie_pkg::OP_UPDATE, 12'd0,   5'd3,  1, bie_pkg::ST_NOT_FOUND, 5'd0, 13'd0},
    '{bie_pkg::OP_COUNT,  12'd0,   5'd31, 1, bie_pkg::ST_OK,        5'd0, 13'd0},
    '{OP_BAD5,            12'hFFF, 5'd31, 1, bie_pkg::ST_INVALID,   5'd0, 13'd0},
    '{OP_BAD7,            12'd0,   5'd0,  1, bie_pkg::ST_INVALID,   5'd0, 13'd0},
    // fill a few rows, extremes of value
    '{bie_pkg::OP_APPEND, 12'd0,   5'd0,  1, bie_pkg::ST_OK,        5'd0, 13'd0},
    '{bie_pkg::OP_APPEND, 12'hFFF, 5'd31, 1, bie_pkg::ST_OK,        5'd0, 13'd0},
    '{bie_pkg::OP_APPEND, 12'd0,   5'd7,  0, 0, 0, 0},
    '{bie_pkg::OP_LOOKUP, 12'd1,   5'd0,  1, bie_pkg::ST_OK,        5'd31, 13'd0},
    '{bie_pkg::OP_LOOKUP, 12'd0,   5'd0,  1, bie_pkg::ST_OK,        5'd0, 13'd0},
    '{bie_pkg::OP_COUNT,  12'd0,   5'd31, 1, bie_pkg::ST_OK,        5'd0, 13'd1},
    // unchanged update, real update, remove, lookup of removed row, lookup of absent row, count
    '{bie_pkg::OP_UPDATE, 12'd2,   5'd7,  1, bie_pkg::ST_NOT_FOUND, 5'd0, 13'd0},
    '{bie_pkg::OP_UPDATE, 12'd2,   5'd12, 0, 0, 0, 0},
    '{bie_pkg::OP_REMOVE, 12'd0,   5'd0,  0, 0, 0, 0},
    '{bie_pkg::OP_LOOKUP, 12'd0,   5'd0,  1, bie_pkg::ST_NOT_FOUND, 5'd0, 13'd0},
    '{bie_pkg::OP_LOOKUP, 12'd3,   5'd0,  1, bie_pkg::ST_NOT_FOUND, 5'd0, 13'd0},
    '{bie_pkg::OP_COUNT,  12'd0,   5'd12, 0, 0, 0, 0}
  };

  // directed ops run after a register change (range mode, small cardinality)
  vec_t range_tbl[] = '{
    '{bie_pkg::OP_APPEND, 12'd0,   5'd3,  1, bie_pkg::ST_INVALID,   5'd0, 13'd0},
    '{bie_pkg::OP_UPDATE, 12'd2,   5'd31, 1, bie_pkg::ST_INVALID,   5'd0, 13'd0},
    '{bie_pkg::OP_COUNT,  12'd0,   5'd2,  1, bie_pkg::ST_INVALID,   5'd0, 13'd0},
    '{bie_pkg::OP_APPEND, 12'd0,   5'd2,  0, 0, 0, 0},
    '{bie_pkg::OP_APPEND, 12'd0,   5'd0,  0, 0, 0, 0},
    '{bie_pkg::OP_LOOKUP, 12'd3,   5'd0,  0, 0, 0, 0},
    '{bie_pkg::OP_LOOKUP, 12'd4,   5'd0,  0, 0, 0, 0},
    '{bie_pkg::OP_UPDATE, 12'd4,   5'd2,  0, 0, 0, 0},
    '{bie_pkg::OP_REMOVE, 12'd4,   5'd0,  0, 0, 0, 0},
    '{bie_pkg::OP_COUNT,  12'd0,   5'd1,  0, 0, 0, 0}
  };

  task automatic run_table(vec_t tbl[]);
    bie_pkg::in_item_t it;
    bie_pkg::out_item_t r;
    foreach (tbl[k]) begin
      it = '{opcode: tbl[k].op, row_id: tbl[k].row, value: tbl[k].val};
      r  = '{status: tbl[k].st, found_value: tbl[k].fv, bit_count: tbl[k].cnt};
      send_op(it, tbl[k].fixed, r);
    end
  endtask

  // random operation: mostly well-formed, rows aimed at the filled region
  function automatic bie_pkg::in_item_t rand_op();
    bie_pkg::in_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.row_id = (idx_rows != 0 && $urandom_range(9) < 8)
                ? 12'($urandom_range(idx_rows - 1)) : 12'($urandom);
    it.value  = ($urandom_range(9) < 8) ? 5'($urandom_range(card_eff() - 1))
                                         : 5'($urandom);
    if (pick < 30)      it.opcode = bie_pkg::OP_APPEND;
    else if (pick < 50) it.opcode = bie_pkg::OP_UPDATE;
    else if (pick < 62) it.opcode = bie_pkg::OP_REMOVE;
    else if (pick < 72) it.opcode = bie_pkg::OP_COUNT;
    else if (pick < 97) it.opcode = bie_pkg::OP_LOOKUP;
    else                it.opcode = 3'($urandom_range(5, 7));
    return it;
  endfunction

  // phase plan: mode and cardinality per slice of random items
  logic       ph_mode [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  logic [5:0] ph_card [6] = '{6'd32, 6'd2, 6'd5, 6'd32, 6'd9, 6'd0};

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_item_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    foreach (idx_maps[m]) idx_maps[m] = '0;
    idx_rows = 0; idx_mode = 1'b0; idx_card = 6'd32;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_table(dir_tbl);
    set_config(1'b1, 6'd3);
    run_table(range_tbl);

    for (int p = 0; p < 6; p++) begin
      // idling phases: light send/heavy stall, then reversed, then none
      if (p < 2)      begin send_idle_pct = 19; recv_stall_pct = 71; end
      else if (p < 4) begin send_idle_pct = 71; recv_stall_pct = 19; end
      else            begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      set_config(ph_mode[p], ph_card[p]);
      for (int k = 0; k < NRANDOM / 6; k++) send_op(rand_op());
    end

    // out-of-range cardinality register above the maximum
    set_config(1'b0, 6'd63);
    for (int k = 0; k < 20; k++) send_op(rand_op());

    drain();
    if (fails == 0) $display("tb_bitmap_index_engine: PASS");
    else            $display("tb_bitmap_index_engine: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/bie_pkg.sv
src/bie_datapath.sv
src/bie_ctrl.sv
src/bitmap_index_engine.sv
verif/tb_bitmap_index_engine.sv
